>>> hw/rtl/cna_pkg.sv
// ----------------------------------------------------------------------------
// cna_pkg
// Shared constants, the pipeline type, and the saturation and step functions of the complex ALU.
// ----------------------------------------------------------------------------
package cna_pkg;

  localparam int FRAC_BITS = 8;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_MOD = 3'd4;

  // quotient and root bits; one bit per iteration stage
  localparam int ITERS  = 17;
  localparam int NUM_W  = 32 + FRAC_BITS;
  localparam int DSH_W  = NUM_W + ITERS;
  localparam int SQ_W   = 2 * ITERS;
  localparam int SR_W   = 20;
  // input reg, product reg, setup reg, iterations, output reg
  localparam int NSTG   = ITERS + 4;

  typedef struct packed {
    logic [2:0]             cmd;
    logic signed [15:0]     simp_re;
    logic signed [15:0]     simp_im;
    logic                   simp_ovf;
    logic                   dz;
    logic [31:0]            den;
    logic [NUM_W-1:0]       rem_re;
    logic [NUM_W-1:0]       rem_im;
    logic [ITERS-1:0]       q_re;
    logic [ITERS-1:0]       q_im;
    logic                   neg_re;
    logic                   neg_im;
    logic                   dov_re;
    logic                   dov_im;
    logic [SQ_W-1:0]        rad;
    logic [SR_W-1:0]        srem;
    logic [ITERS-1:0]       root;
  } iter_t;

  // {overflow, value}
  function automatic logic [16:0] sat16(logic signed [34:0] v);
    logic [16:0] r;
    if (v > 35'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -35'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  // one restoring divide bit for both parts, one root bit
  function automatic iter_t iter_step(iter_t s, int k);
    iter_t            o;
    logic [DSH_W-1:0] dsh;
    logic [DSH_W-1:0] rw;
    logic [SR_W-1:0]  cur;
    logic [SR_W-1:0]  trial;
    o   = s;
    dsh = DSH_W'(s.den) << k;
    rw  = DSH_W'(s.rem_re);
    if (rw >= dsh) begin
      o.rem_re = NUM_W'(rw - dsh);
      o.q_re   = s.q_re | (ITERS'(1) << k);
    end
    rw = DSH_W'(s.rem_im);
    if (rw >= dsh) begin
      o.rem_im = NUM_W'(rw - dsh);
      o.q_im   = s.q_im | (ITERS'(1) << k);
    end
    cur   = {s.srem[SR_W-3:0], s.rad[SQ_W-1:SQ_W-2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = s.rad << 2;
    if (cur >= trial) begin
      o.srem = cur - trial;
      o.root = {s.root[ITERS-2:0], 1'b1};
    end else begin
      o.srem = cur;
      o.root = {s.root[ITERS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/cna_prep.sv
// ----------------------------------------------------------------------------
// cna_prep
// Product stage and setup stage: multiplies, add/sub/mul results, divider and
// root operands.
// ----------------------------------------------------------------------------
module cna_prep import cna_pkg::*; (
  input  logic               clk,
  input  logic               en_prod,
  input  logic               en_setup,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output iter_t              setup_r
);

  logic [2:0]         cmd_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [31:0] p_aa_r, p_ai_r, p_bb_r, p_bi_r;
  logic signed [16:0] add_re_r, add_im_r;

  always_ff @(posedge clk) begin
    if (en_prod) begin
      cmd_r  <= cmd;
      p_rr_r <= a_real * b_real;
      p_ii_r <= a_imag * b_imag;
      p_ri_r <= a_real * b_imag;
      p_ir_r <= a_imag * b_real;
      p_aa_r <= a_real * a_real;
      p_ai_r <= a_imag * a_imag;
      p_bb_r <= b_real * b_real;
      p_bi_r <= b_imag * b_imag;
      if (cmd == CMD_SUB) begin
        add_re_r <= 17'(a_real) - 17'(b_real);
        add_im_r <= 17'(a_imag) - 17'(b_imag);
      end else begin
        add_re_r <= 17'(a_real) + 17'(b_real);
        add_im_r <= 17'(a_imag) + 17'(b_imag);
      end
    end
  end

  logic signed [32:0] m_re, m_im, n_re, n_im;
  logic signed [32:0] m_re_sh, m_im_sh;
  logic [31:0]        mag_re, mag_im, den;
  logic [16:0]        s_re, s_im;
  iter_t              setup_nxt;

  always_comb begin
    m_re    = 33'(p_rr_r) - 33'(p_ii_r);
    m_im    = 33'(p_ri_r) + 33'(p_ir_r);
    n_re    = 33'(p_rr_r) + 33'(p_ii_r);
    n_im    = 33'(p_ir_r) - 33'(p_ri_r);
    m_re_sh = m_re >>> FRAC_BITS;
    m_im_sh = m_im >>> FRAC_BITS;
    mag_re  = n_re[32] ? 32'(-n_re) : n_re[31:0];
    mag_im  = n_im[32] ? 32'(-n_im) : n_im[31:0];
    den     = 32'(p_bb_r) + 32'(p_bi_r);

    if (cmd_r == CMD_MUL) begin
      s_re = sat16(35'(m_re_sh));
      s_im = sat16(35'(m_im_sh));
    end else begin
      s_re = sat16(35'(add_re_r));
      s_im = sat16(35'(add_im_r));
    end

    setup_nxt          = '0;
    setup_nxt.cmd      = cmd_r;
    setup_nxt.simp_re  = s_re[15:0];
    setup_nxt.simp_im  = s_im[15:0];
    setup_nxt.simp_ovf = s_re[16] | s_im[16];
    setup_nxt.dz       = (den == 32'd0);
    setup_nxt.den      = den;
    setup_nxt.rem_re   = {mag_re, FRAC_BITS'(0)};
    setup_nxt.rem_im   = {mag_im, FRAC_BITS'(0)};
    setup_nxt.neg_re   = n_re[32];
    setup_nxt.neg_im   = n_im[32];
    // quotient would need more than ITERS bits
    setup_nxt.dov_re   = {mag_re, FRAC_BITS'(0)} >= {den, ITERS'(0)};
    setup_nxt.dov_im   = {mag_im, FRAC_BITS'(0)} >= {den, ITERS'(0)};
    setup_nxt.rad      = {2'b00, 32'(p_aa_r) + 32'(p_ai_r)};
  end

  always_ff @(posedge clk) begin
    if (en_setup) begin
      setup_r <= setup_nxt;
    end
  end

endmodule

>>> hw/rtl/complex_number_alu.sv
// ----------------------------------------------------------------------------
// complex_number_alu
// Complex add, subtract, multiply, divide and modulus on signed Q8.8 parts.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  in      | in_valid/in_ready, in_cmd, in_a_*, in_b_*    | request in
//  out     | out_valid/out_ready, out_res_*, out_overflow,| result out
//          | out_div_by_zero                              |
//
//  21 register stages: input, products, setup, 17 divide/root bit stages,
//  output. One request enters every cycle while in_ready is high.
//  Each stage holds its own valid bit and advances when the stage after it
//  is empty or advancing, so bubbles close up under a stall.
//  Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module complex_number_alu import cna_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [15:0] in_a_real,
  input  logic signed [15:0] in_a_imag,
  input  logic signed [15:0] in_b_real,
  input  logic signed [15:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_res_real,
  output logic signed [15:0] out_res_imag,
  output logic               out_overflow,
  output logic               out_div_by_zero
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  assign rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_rdy
    assign rdy[i] = !v_r[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

  logic [2:0]         cmd_r;
  logic signed [15:0] ar_r, ai_r, br_r, bi_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd_r <= in_cmd;
      ar_r  <= in_a_real;
      ai_r  <= in_a_imag;
      br_r  <= in_b_real;
      bi_r  <= in_b_imag;
    end
  end

  iter_t setup_r;

  cna_prep u_prep (
    .clk      (clk),
    .en_prod  (rdy[1]),
    .en_setup (rdy[2]),
    .cmd      (cmd_r),
    .a_real   (ar_r),
    .a_imag   (ai_r),
    .b_real   (br_r),
    .b_imag   (bi_r),
    .setup_r  (setup_r)
  );

  iter_t iter_r [ITERS];
  iter_t iter_in [ITERS];

  assign iter_in[0] = setup_r;
  for (genvar j = 1; j < ITERS; j++) begin : g_chain
    assign iter_in[j] = iter_r[j-1];
  end

  for (genvar j = 0; j < ITERS; j++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rdy[3+j]) begin
        iter_r[j] <= iter_step(iter_in[j], ITERS - 1 - j);
      end
    end
  end

  iter_t              fin;
  logic signed [34:0] q_re_s, q_im_s;
  logic [16:0]        d_re, d_im;
  logic signed [15:0] res_re_nxt, res_im_nxt;
  logic               ovf_nxt, dz_nxt;

  always_comb begin
    fin    = iter_r[ITERS-1];
    q_re_s = fin.neg_re ? -35'(fin.q_re) : 35'(fin.q_re);
    q_im_s = fin.neg_im ? -35'(fin.q_im) : 35'(fin.q_im);
    d_re   = fin.dov_re ? {1'b1, fin.neg_re ? 16'h8000 : 16'h7fff} : sat16(q_re_s);
    d_im   = fin.dov_im ? {1'b1, fin.neg_im ? 16'h8000 : 16'h7fff} : sat16(q_im_s);

    res_re_nxt = '0;
    res_im_nxt = '0;
    ovf_nxt    = 1'b0;
    dz_nxt     = 1'b0;
    case (fin.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        res_re_nxt = fin.simp_re;
        res_im_nxt = fin.simp_im;
        ovf_nxt    = fin.simp_ovf;
      end
      CMD_DIV: begin
        if (fin.dz) begin
          dz_nxt = 1'b1;
        end else begin
          res_re_nxt = d_re[15:0];
          res_im_nxt = d_im[15:0];
          ovf_nxt    = d_re[16] | d_im[16];
        end
      end
      CMD_MOD: begin
        if (fin.root > ITERS'(32767)) begin
          res_re_nxt = 16'sh7fff;
          ovf_nxt    = 1'b1;
        end else begin
          res_re_nxt = fin.root[15:0];
        end
      end
      default: begin
        res_re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_res_real    <= res_re_nxt;
      out_res_imag    <= res_im_nxt;
      out_overflow    <= ovf_nxt;
      out_div_by_zero <= dz_nxt;
    end
  end

endmodule
